@@ rtl/core/scc_pkg.sv @@
// scc_pkg: sizes, item structs, controller states and the command/response
// structs between the search controller and the adjacency store.
// Used by every module of the strongly connected components block except scc_ram.
package scc_pkg;

    // sizing
    localparam int MAX_NODES = 64;
    localparam int MAX_EDGES = 512;
    localparam int NODE_W    = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
    localparam int CNT_W     = $clog2(MAX_NODES + 1);
    localparam int EDGE_W    = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int PTR_W     = $clog2(MAX_EDGES + 1);
    localparam int CFG_W     = 7;
    localparam int ID_W      = 7;
    localparam int COMP_W    = 6;

    // end-of-list pointer
    localparam logic [PTR_W-1:0] NIL = PTR_W'(MAX_EDGES);

    // input item kinds
    localparam logic KIND_EDGE = 1'b0;
    localparam logic KIND_GO   = 1'b1;

    // search directions
    localparam logic DIR_FWD = 1'b0;
    localparam logic DIR_REV = 1'b1;

    typedef struct packed {
        logic            kind;
        logic [ID_W-1:0] from_node;
        logic [ID_W-1:0] to_node;
    } t_in_item;

    typedef struct packed {
        logic [ID_W-1:0]   node_id;
        logic [COMP_W-1:0] component_index;
        logic              end_of_component;
        logic              last;
        logic              edge_overflow;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE_WR,
        S_P1_ROOT,
        S_HEAD,
        S_STEP,
        S_EDGE_RD,
        S_RESTORE,
        S_P2_POP,
        S_P2_ROOT,
        S_FLUSH
    } t_state;

    // controller to adjacency store
    typedef struct packed {
        logic              app_start;
        logic              app_commit;
        logic [NODE_W-1:0] app_from;
        logic [NODE_W-1:0] app_to;
        logic [EDGE_W-1:0] app_edge;
        logic              rd_head;
        logic              rd_link;
        logic              rd_dir;
        logic [NODE_W-1:0] rd_node;
        logic [EDGE_W-1:0] rd_ptr;
        logic              clear;
    } t_gcmd;

    // adjacency store to controller, valid in the cycle after a read
    typedef struct packed {
        logic [PTR_W-1:0]  head;
        logic [NODE_W-1:0] link_node;
        logic [PTR_W-1:0]  link_next;
    } t_gresp;

endpackage

@@ rtl/core/scc_ram.sv @@
// scc_ram: generic single write port, single read port memory with a
// registered read. No dependencies.
module scc_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 64
) (
    input  logic                                       i_clk,
    input  logic                                       i_we,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                           i_wdata,
    input  logic                                       i_re,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                           o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // write port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
    end

    // registered read port
    always_ff @(posedge i_clk) begin
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

@@ rtl/core/scc_graph.sv @@
// scc_graph: forward and reverse adjacency lists (head, tail, link node and
// link next memories per direction) with per-node list valid bits.
// Depends on scc_pkg and scc_ram.
module scc_graph import scc_pkg::*; (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  t_gcmd  i_cmd,
    output t_gresp o_resp
);

    logic [1:0][MAX_NODES-1:0] r_valid, n_valid;
    logic [NODE_W-1:0]         r_own [2];
    logic [1:0]                r_tv;
    logic [EDGE_W-1:0]         r_edge;
    logic                      r_hv;
    logic                      r_dir;

    logic [NODE_W-1:0] w_own [2];
    logic [NODE_W-1:0] w_tgt [2];
    logic [PTR_W-1:0]  w_tail_q [2];
    logic [PTR_W-1:0]  w_head_q [2];
    logic [PTR_W-1:0]  w_next_q [2];
    logic [NODE_W-1:0] w_node_q [2];

    // forward lists are owned by the source, reverse lists by the destination
    assign w_own[0] = i_cmd.app_from;
    assign w_own[1] = i_cmd.app_to;
    assign w_tgt[0] = i_cmd.app_to;
    assign w_tgt[1] = i_cmd.app_from;

    // list valid bits: set on append, cleared with the graph
    always_comb begin
        n_valid = r_valid;
        if (i_cmd.clear) begin
            n_valid = '0;
        end else if (i_cmd.app_commit) begin
            n_valid[0][r_own[0]] = 1'b1;
            n_valid[1][r_own[1]] = 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= '0;
        end else begin
            r_valid <= n_valid;
        end
    end

    // append and read bookkeeping
    always_ff @(posedge i_clk) begin
        if (i_cmd.app_start) begin
            r_own[0] <= w_own[0];
            r_own[1] <= w_own[1];
            r_tv[0]  <= r_valid[0][w_own[0]];
            r_tv[1]  <= r_valid[1][w_own[1]];
            r_edge   <= i_cmd.app_edge;
        end
        if (i_cmd.rd_head) begin
            r_hv <= r_valid[i_cmd.rd_dir][i_cmd.rd_node];
        end
        if (i_cmd.rd_head || i_cmd.rd_link) begin
            r_dir <= i_cmd.rd_dir;
        end
    end

    // memories of one direction
    for (genvar d = 0; d < 2; d++) begin : g_dir
        logic              w_rd_mine;
        logic              w_next_we;
        logic [EDGE_W-1:0] w_next_addr;
        logic [PTR_W-1:0]  w_next_data;

        assign w_rd_mine   = (i_cmd.rd_dir == 1'(d));
        assign w_next_we   = i_cmd.app_start || (i_cmd.app_commit && r_tv[d]);
        assign w_next_addr = i_cmd.app_start ? i_cmd.app_edge : w_tail_q[d][EDGE_W-1:0];
        assign w_next_data = i_cmd.app_start ? NIL : PTR_W'(r_edge);

        scc_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_tail (
            .i_clk   (i_clk),
            .i_we    (i_cmd.app_commit),
            .i_waddr (r_own[d]),
            .i_wdata (PTR_W'(r_edge)),
            .i_re    (i_cmd.app_start),
            .i_raddr (w_own[d]),
            .o_rdata (w_tail_q[d])
        );

        scc_ram #(.WIDTH(PTR_W), .DEPTH(MAX_NODES)) u_head (
            .i_clk   (i_clk),
            .i_we    (i_cmd.app_commit && !r_tv[d]),
            .i_waddr (r_own[d]),
            .i_wdata (PTR_W'(r_edge)),
            .i_re    (i_cmd.rd_head && w_rd_mine),
            .i_raddr (i_cmd.rd_node),
            .o_rdata (w_head_q[d])
        );

        scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_EDGES)) u_node (
            .i_clk   (i_clk),
            .i_we    (i_cmd.app_start),
            .i_waddr (i_cmd.app_edge),
            .i_wdata (w_tgt[d]),
            .i_re    (i_cmd.rd_link && w_rd_mine),
            .i_raddr (i_cmd.rd_ptr),
            .o_rdata (w_node_q[d])
        );

        scc_ram #(.WIDTH(PTR_W), .DEPTH(MAX_EDGES)) u_next (
            .i_clk   (i_clk),
            .i_we    (w_next_we),
            .i_waddr (w_next_addr),
            .i_wdata (w_next_data),
            .i_re    (i_cmd.rd_link && w_rd_mine),
            .i_raddr (i_cmd.rd_ptr),
            .o_rdata (w_next_q[d])
        );
    end

    // response, an empty list reads as end of list
    assign o_resp.head      = r_hv ? w_head_q[r_dir] : NIL;
    assign o_resp.link_node = w_node_q[r_dir];
    assign o_resp.link_next = w_next_q[r_dir];

endmodule

@@ rtl/core/scc_walk.sv @@
// scc_walk: item intake, two-pass depth-first search sequencer with search
// and finish stack memories, visited bits and the result output stage.
// Depends on scc_pkg and scc_ram.
module scc_walk import scc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic [CFG_W-1:0] i_n,
    input  logic             i_in_valid,
    input  t_in_item         i_in_item,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  logic             i_out_stall,
    output t_gcmd            o_gcmd,
    input  t_gresp           i_gresp
);

    t_state                r_state, n_state;
    logic                  r_pass, n_pass;
    logic [CFG_W-1:0]      r_root, n_root;
    logic [NODE_W-1:0]     r_top_node, n_top_node;
    logic [PTR_W-1:0]      r_top_cur, n_top_cur;
    logic [CNT_W-1:0]      r_sp, n_sp;
    logic [CNT_W-1:0]      r_fin, n_fin;
    logic [COMP_W-1:0]     r_comp, n_comp;
    logic [MAX_NODES-1:0]  r_vis1, n_vis1;
    logic [MAX_NODES-1:0]  r_vis2, n_vis2;
    logic [PTR_W-1:0]      r_edges, n_edges;
    logic                  r_ovf, n_ovf;
    t_out_item             r_out, n_out;
    logic                  r_out_vld, n_out_vld;
    t_out_item             r_pend, n_pend;
    logic                  r_pend_vld, n_pend_vld;

    // stack memory controls
    logic                       w_sw_we, w_sw_re;
    logic [NODE_W-1:0]          w_sw_waddr, w_sw_raddr;
    logic [NODE_W+PTR_W-1:0]    w_sw_wdata, w_sw_q;
    logic                       w_fw_we, w_fw_re;
    logic [NODE_W-1:0]          w_fw_waddr, w_fw_raddr;
    logic [NODE_W-1:0]          w_fw_q;

    // shared conditions
    logic                  w_out_take, w_out_free, w_emit_ok;
    logic                  w_in_range;
    logic [NODE_W-1:0]     w_v, w_root_idx;
    logic                  w_v_new, w_v_go, w_now_new;
    logic                  w_emit;
    logic [NODE_W-1:0]     w_emit_node;

    assign w_out_take = r_out_vld && !i_out_stall;
    assign w_out_free = !r_out_vld || w_out_take;
    assign w_emit_ok  = !r_pend_vld || w_out_free;

    assign w_in_range = (i_in_item.from_node != '0) && (i_in_item.from_node <= i_n)
                     && (i_in_item.to_node != '0) && (i_in_item.to_node <= i_n);

    assign w_root_idx = NODE_W'(r_root);
    assign w_v        = i_gresp.link_node;
    assign w_v_new    = (CFG_W'(w_v) < i_n)
                     && !(r_pass ? r_vis2[w_v] : r_vis1[w_v])
                     && (r_sp < CNT_W'(MAX_NODES));
    assign w_v_go     = w_v_new && (!r_pass || w_emit_ok);
    assign w_now_new  = (CFG_W'(w_fw_q) < i_n) && !r_vis2[w_fw_q];

    assign o_in_stall = (r_state != S_IDLE);

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.kind == KIND_GO) begin
                        n_state = S_P1_ROOT;
                    end else if (w_in_range && (r_edges != NIL)) begin
                        n_state = S_EDGE_WR;
                    end
                end
            end
            S_EDGE_WR: n_state = S_IDLE;
            S_P1_ROOT: begin
                if (r_root == i_n) begin
                    n_state = S_P2_POP;
                end else if (!r_vis1[w_root_idx]) begin
                    n_state = S_HEAD;
                end
            end
            S_HEAD: n_state = S_STEP;
            S_STEP: begin
                if (r_top_cur != NIL) begin
                    n_state = S_EDGE_RD;
                end else if (r_sp == CNT_W'(1)) begin
                    n_state = r_pass ? S_P2_POP : S_P1_ROOT;
                end else begin
                    n_state = S_RESTORE;
                end
            end
            S_RESTORE: n_state = S_STEP;
            S_EDGE_RD: begin
                if (!w_v_new) begin
                    n_state = S_STEP;
                end else if (w_v_go) begin
                    n_state = S_HEAD;
                end
            end
            S_P2_POP: n_state = (r_fin != '0) ? S_P2_ROOT : S_FLUSH;
            S_P2_ROOT: begin
                if (!w_now_new) begin
                    n_state = S_P2_POP;
                end else if (w_emit_ok) begin
                    n_state = S_HEAD;
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld || w_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // datapath and memory controls
    always_comb begin
        n_pass     = r_pass;
        n_root     = r_root;
        n_top_node = r_top_node;
        n_top_cur  = r_top_cur;
        n_sp       = r_sp;
        n_fin      = r_fin;
        n_comp     = r_comp;
        n_vis1     = r_vis1;
        n_vis2     = r_vis2;
        n_edges    = r_edges;
        n_ovf      = r_ovf;
        n_out      = r_out;
        n_out_vld  = r_out_vld && !w_out_take;
        n_pend     = r_pend;
        n_pend_vld = r_pend_vld;
        o_gcmd     = '0;
        w_sw_we    = 1'b0;
        w_sw_re    = 1'b0;
        w_sw_waddr = NODE_W'(r_sp - CNT_W'(1));
        w_sw_raddr = NODE_W'(r_sp - CNT_W'(2));
        w_sw_wdata = {r_top_node, i_gresp.link_next};
        w_fw_we    = 1'b0;
        w_fw_re    = 1'b0;
        w_fw_waddr = NODE_W'(r_fin);
        w_fw_raddr = NODE_W'(r_fin - CNT_W'(1));
        w_emit     = 1'b0;
        w_emit_node = w_fw_q;

        o_gcmd.app_from = NODE_W'(i_in_item.from_node - ID_W'(1));
        o_gcmd.app_to   = NODE_W'(i_in_item.to_node - ID_W'(1));
        o_gcmd.app_edge = r_edges[EDGE_W-1:0];
        o_gcmd.rd_dir   = r_pass;
        o_gcmd.rd_ptr   = r_top_cur[EDGE_W-1:0];
        o_gcmd.rd_node  = w_v;

        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_in_item.kind == KIND_GO) begin
                        n_pass = DIR_FWD;
                        n_root = '0;
                        n_fin  = '0;
                        n_comp = '0;
                    end else if (w_in_range) begin
                        if (r_edges == NIL) begin
                            n_ovf = 1'b1;
                        end else begin
                            o_gcmd.app_start = 1'b1;
                            n_edges = r_edges + PTR_W'(1);
                        end
                    end
                end
            end
            S_EDGE_WR: o_gcmd.app_commit = 1'b1;
            S_P1_ROOT: begin
                if (r_root == i_n) begin
                    // all roots done: second pass walks the reverse lists
                    n_pass = DIR_REV;
                end else begin
                    if (r_vis1[w_root_idx]) begin
                        n_root = r_root + CFG_W'(1);
                    end else begin
                        n_vis1[w_root_idx] = 1'b1;
                        n_top_node     = w_root_idx;
                        n_sp           = CNT_W'(1);
                        o_gcmd.rd_head = 1'b1;
                        o_gcmd.rd_node = w_root_idx;
                    end
                end
            end
            S_HEAD: n_top_cur = i_gresp.head;
            S_STEP: begin
                if (r_top_cur != NIL) begin
                    o_gcmd.rd_link = 1'b1;
                end else begin
                    // node finished: pop it
                    n_sp = r_sp - CNT_W'(1);
                    if (!r_pass && (r_fin < CNT_W'(MAX_NODES))) begin
                        w_fw_we = 1'b1;
                        n_fin   = r_fin + CNT_W'(1);
                    end
                    if (r_sp == CNT_W'(1)) begin
                        if (r_pass) begin
                            n_pend.end_of_component = 1'b1;
                            n_comp = r_comp + COMP_W'(1);
                        end else begin
                            n_root = r_root + CFG_W'(1);
                        end
                    end else begin
                        w_sw_re = 1'b1;
                    end
                end
            end
            S_RESTORE: {n_top_node, n_top_cur} = w_sw_q;
            S_EDGE_RD: begin
                if (!w_v_new) begin
                    n_top_cur = i_gresp.link_next;
                end else if (w_v_go) begin
                    // descend: save the parent with its advanced cursor
                    if (r_pass) begin
                        n_vis2[w_v] = 1'b1;
                    end else begin
                        n_vis1[w_v] = 1'b1;
                    end
                    w_sw_we        = 1'b1;
                    n_sp           = r_sp + CNT_W'(1);
                    n_top_node     = w_v;
                    o_gcmd.rd_head = 1'b1;
                    w_emit         = r_pass;
                    w_emit_node    = w_v;
                end
            end
            S_P2_POP: begin
                if (r_fin != '0) begin
                    w_fw_re = 1'b1;
                    n_fin   = r_fin - CNT_W'(1);
                end
            end
            S_P2_ROOT: begin
                if (w_now_new && w_emit_ok) begin
                    n_vis2[w_fw_q] = 1'b1;
                    n_top_node     = w_fw_q;
                    n_sp           = CNT_W'(1);
                    o_gcmd.rd_head = 1'b1;
                    o_gcmd.rd_node = w_fw_q;
                    w_emit         = 1'b1;
                end
            end
            S_FLUSH: begin
                if (!r_pend_vld || w_out_free) begin
                    if (r_pend_vld) begin
                        n_out      = r_pend;
                        n_out.last = 1'b1;
                        n_out_vld  = 1'b1;
                        n_pend_vld = 1'b0;
                    end
                    n_vis1       = '0;
                    n_vis2       = '0;
                    n_edges      = '0;
                    n_ovf        = 1'b0;
                    o_gcmd.clear = 1'b1;
                end
            end
            default: ;
        endcase

        // a newly visited node waits in the pending slot until its end mark is known
        if (w_emit) begin
            if (r_pend_vld) begin
                n_out      = r_pend;
                n_out.last = 1'b0;
                n_out_vld  = 1'b1;
            end
            n_pend.node_id          = ID_W'(w_emit_node) + ID_W'(1);
            n_pend.component_index  = r_comp;
            n_pend.end_of_component = 1'b0;
            n_pend.last             = 1'b0;
            n_pend.edge_overflow    = r_ovf;
            n_pend_vld              = 1'b1;
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_vis1     <= '0;
            r_vis2     <= '0;
            r_edges    <= '0;
            r_ovf      <= 1'b0;
            r_out_vld  <= 1'b0;
            r_pend_vld <= 1'b0;
            r_sp       <= '0;
            r_fin      <= '0;
        end else begin
            r_state    <= n_state;
            r_vis1     <= n_vis1;
            r_vis2     <= n_vis2;
            r_edges    <= n_edges;
            r_ovf      <= n_ovf;
            r_out_vld  <= n_out_vld;
            r_pend_vld <= n_pend_vld;
            r_sp       <= n_sp;
            r_fin      <= n_fin;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        r_pass     <= n_pass;
        r_root     <= n_root;
        r_top_node <= n_top_node;
        r_top_cur  <= n_top_cur;
        r_comp     <= n_comp;
        r_out      <= n_out;
        r_pend     <= n_pend;
    end

    // search stack: entries below the top of stack
    scc_ram #(.WIDTH(NODE_W + PTR_W), .DEPTH(MAX_NODES)) u_search_stack (
        .i_clk   (i_clk),
        .i_we    (w_sw_we),
        .i_waddr (w_sw_waddr),
        .i_wdata (w_sw_wdata),
        .i_re    (w_sw_re),
        .i_raddr (w_sw_raddr),
        .o_rdata (w_sw_q)
    );

    // finish order of the first pass
    scc_ram #(.WIDTH(NODE_W), .DEPTH(MAX_NODES)) u_finish_stack (
        .i_clk   (i_clk),
        .i_we    (w_fw_we),
        .i_waddr (w_fw_waddr),
        .i_wdata (r_top_node),
        .i_re    (w_fw_re),
        .i_raddr (w_fw_raddr),
        .o_rdata (w_fw_q)
    );

    assign o_out_valid = r_out_vld;
    assign o_out_item  = r_out;

    // stack depths never exceed the node limit
    a_depth: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_sp <= CNT_W'(MAX_NODES)) && (r_fin <= CNT_W'(MAX_NODES)))
        else $error("stack depth beyond node limit");

    // a live cursor is always followed by its link read
    a_cursor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_STEP && r_top_cur != NIL) |=> (r_state == S_EDGE_RD))
        else $error("cursor not followed");

    // the first pass never produces a result
    a_pass1_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (!r_pass && (r_state == S_STEP || r_state == S_EDGE_RD || r_state == S_P1_ROOT))
        |=> !$rose(r_pend_vld))
        else $error("result during first pass");

    // leaving flush leaves a cleared graph and nothing pending
    a_cleared: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FLUSH && n_state == S_IDLE)
        |=> (r_vis1 == '0 && r_vis2 == '0 && r_edges == '0 && !r_pend_vld))
        else $error("graph not cleared after search");

endmodule

@@ rtl/core/strongly_connected_components.sv @@
// strongly_connected_components: Kosaraju component search over a stored
// directed graph. Depends on scc_pkg, scc_graph and scc_walk.
//
// Edge items (kind 0) append to forward and reverse adjacency lists with a
// tail read, then the link write-back into the list memories. A go item
// (kind 1) runs a depth-first pass over the forward lists, then a second
// pass over the reverse lists in reverse finish order, giving one result
// per node with its component number and end marks; it then clears the
// graph. A go item's run time grows with the nodes and stored edges in each
// pass and with the finish-order pops of the second pass, and is lengthened
// by any stall of the result receiver; every step of the search waits on
// the registered read of the adjacency and stack memories. No clearing pass
// is needed after reset. The user must write node_count only while the
// block is idle; the block itself does not enforce it.
module strongly_connected_components import scc_pkg::*; (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    input  t_in_item         i_in_item,
    output logic             o_in_stall,
    output logic             o_out_valid,
    output t_out_item        o_out_item,
    input  logic             i_out_stall,
    input  logic             i_cfg_valid,
    input  logic [CFG_W-1:0] i_cfg_data,
    output logic             o_cfg_ready
);

    logic [CFG_W-1:0] r_node_count;
    logic [CFG_W-1:0] w_n;
    t_gcmd            w_gcmd;
    t_gresp           w_gresp;

    // node count register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_node_count <= CFG_W'(1);
        end else if (i_cfg_valid && o_cfg_ready) begin
            r_node_count <= i_cfg_data;
        end
    end

    assign o_cfg_ready = 1'b1;

    // effective node count, saturated at the node limit
    assign w_n = (r_node_count > CFG_W'(MAX_NODES)) ? CFG_W'(MAX_NODES) : r_node_count;

    scc_graph u_graph (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cmd   (w_gcmd),
        .o_resp  (w_gresp)
    );

    scc_walk u_walk (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_n         (w_n),
        .i_in_valid  (i_in_valid),
        .i_in_item   (i_in_item),
        .o_in_stall  (o_in_stall),
        .o_out_valid (o_out_valid),
        .o_out_item  (o_out_item),
        .i_out_stall (i_out_stall),
        .o_gcmd      (w_gcmd),
        .i_gresp     (w_gresp)
    );

endmodule

@@ tb/tb_strongly_connected_components.sv @@
// tb_strongly_connected_components: self-checking bench for the component search block.
// Depends on scc_pkg and strongly_connected_components; predicts results from its own graph model.
module tb_strongly_connected_components;
    import scc_pkg::*;

    logic             i_clk = 1'b0;
    logic             i_rst_n = 1'b0;
    logic             in_valid = 1'b0;
    t_in_item         in_item = '0;
    logic             in_stall;
    logic             out_valid;
    t_out_item        out_item;
    logic             out_stall = 1'b0;
    logic             cfg_valid = 1'b0;
    logic [CFG_W-1:0] cfg_data = '0;
    logic             cfg_ready;

    strongly_connected_components i_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (in_valid),
        .i_in_item   (in_item),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_item  (out_item),
        .i_out_stall (out_stall),
        .i_cfg_valid (cfg_valid),
        .i_cfg_data  (cfg_data),
        .o_cfg_ready (cfg_ready)
    );

    always #5 i_clk = ~i_clk;

    // predictor state: graph as per-node edge lists in insertion order
    int        g_nodes;
    int        g_edges;
    bit        g_overflow;
    int        fwd_adj[MAX_NODES][$];
    int        rev_adj[MAX_NODES][$];
    t_out_item expected_nodes[$];
    t_in_item  pending_items[$];

    int  mismatches = 0;
    int  results_seen = 0;
    int  go_count = 0;
    int  edge_count = 0;
    bit  quiet_tail = 1'b0;
    bit  hold_armed = 1'b0;
    bit  hold_done = 1'b0;
    int  hold_cycles = 0;
    int  tx_gap = 0;
    int  rx_gap = 0;

    function automatic void clear_model();
        g_edges = 0;
        g_overflow = 1'b0;
        for (int i = 0; i < MAX_NODES; i++) begin
            fwd_adj[i].delete();
            rev_adj[i].delete();
        end
    endfunction

    function automatic void add_expected(input t_out_item r);
        expected_nodes.insert(expected_nodes.size(), r);
    endfunction

    function automatic void queue_item(input t_in_item it);
        pending_items.insert(pending_items.size(), it);
    endfunction

    // explicit-stack depth-first walk; pass one records finish order,
    // pass two appends preorder results
    function automatic void walk_lists(input int root, input bit second, input int comp,
                                       ref bit seen[MAX_NODES], ref int finish[$]);
        int stk_node[$];
        int stk_cur[$];
        int top;
        int v;
        t_out_item r;
        seen[root] = 1'b1;
        if (second) begin
            r = '0;
            r.node_id = ID_W'(root + 1);
            r.component_index = COMP_W'(comp);
            r.edge_overflow = g_overflow;
            add_expected(r);
        end
        stk_node.insert(stk_node.size(), root);
        stk_cur.insert(stk_cur.size(), 0);
        while (stk_node.size() > 0) begin
            top = stk_node.size() - 1;
            if (second ? (stk_cur[top] >= rev_adj[stk_node[top]].size())
                       : (stk_cur[top] >= fwd_adj[stk_node[top]].size())) begin
                if (!second && finish.size() < MAX_NODES)
                    finish.insert(finish.size(), stk_node[top]);
                void'(stk_node.pop_back());
                void'(stk_cur.pop_back());
            end else begin
                v = second ? rev_adj[stk_node[top]][stk_cur[top]]
                           : fwd_adj[stk_node[top]][stk_cur[top]];
                stk_cur[top]++;
                if (v < g_nodes && !seen[v] && stk_node.size() < MAX_NODES) begin
                    seen[v] = 1'b1;
                    if (second) begin
                        r = '0;
                        r.node_id = ID_W'(v + 1);
                        r.component_index = COMP_W'(comp);
                        r.edge_overflow = g_overflow;
                        add_expected(r);
                    end
                    stk_node.insert(stk_node.size(), v);
                    stk_cur.insert(stk_cur.size(), 0);
                end
            end
        end
    endfunction

    function automatic void predict_components(input t_in_item it);
        bit seen1[MAX_NODES];
        bit seen2[MAX_NODES];
        int finish[$];
        int dummy[$];
        int comp;
        int now;
        int start;
        if (it.kind == KIND_EDGE) begin
            if (it.from_node < 1 || it.from_node > g_nodes ||
                it.to_node < 1 || it.to_node > g_nodes) return;
            if (g_edges >= MAX_EDGES) begin
                g_overflow = 1'b1;
                return;
            end
            fwd_adj[it.from_node - 1].insert(fwd_adj[it.from_node - 1].size(),
                                             it.to_node - 1);
            rev_adj[it.to_node - 1].insert(rev_adj[it.to_node - 1].size(),
                                           it.from_node - 1);
            g_edges++;
            return;
        end
        seen1 = '{default: 0};
        seen2 = '{default: 0};
        for (int r = 0; r < g_nodes; r++)
            if (!seen1[r]) walk_lists(r, 1'b0, 0, seen1, finish);
        comp = 0;
        start = expected_nodes.size();
        while (finish.size() > 0) begin
            now = finish.pop_back();
            if (now < g_nodes && !seen2[now]) begin
                walk_lists(now, 1'b1, comp, seen2, dummy);
                expected_nodes[expected_nodes.size() - 1].end_of_component = 1'b1;
                comp++;
            end
        end
        if (expected_nodes.size() > start)
            expected_nodes[expected_nodes.size() - 1].last = 1'b1;
        clear_model();
    endfunction

    // sender: pops pending items, random idle bursts
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (in_valid && !in_stall) begin
                predict_components(in_item);
                if (in_item.kind == KIND_GO) go_count++; else edge_count++;
            end
            if (!in_valid || !in_stall) begin
                if (tx_gap > 0) begin
                    tx_gap <= tx_gap - 1;
                    in_valid <= 1'b0;
                end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                    tx_gap <= $urandom_range(0, 3);
                    in_valid <= 1'b0;
                end else if (pending_items.size() > 0) begin
                    in_item <= pending_items.pop_front();
                    in_valid <= 1'b1;
                end else begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // long receiver hold-off, counted once it is armed
    always @(posedge i_clk) begin
        if (hold_cycles > 0) begin
            hold_cycles <= hold_cycles - 1;
        end else if (hold_armed && !hold_done) begin
            hold_cycles <= 300;
            hold_done <= 1'b1;
        end
    end

    // receiver: stall bursts, long hold-off, and field checks
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (out_valid && !out_stall) begin
                results_seen++;
                if (expected_nodes.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result node=%0d", out_item.node_id);
                end else begin
                    t_out_item e;
                    e = expected_nodes.pop_front();
                    if (e !== out_item) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch exp id=%0d comp=%0d eoc=%0b last=%0b ",
                                      "ovf=%0b got id=%0d comp=%0d eoc=%0b last=%0b ovf=%0b"},
                                     e.node_id, e.component_index, e.end_of_component,
                                     e.last, e.edge_overflow, out_item.node_id,
                                     out_item.component_index, out_item.end_of_component,
                                     out_item.last, out_item.edge_overflow);
                    end
                end
            end
            if (hold_cycles > 0) begin
                out_stall <= 1'b1;
            end else if (rx_gap > 0) begin
                rx_gap <= rx_gap - 1;
                out_stall <= 1'b1;
            end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
                rx_gap <= $urandom_range(0, 3);
                out_stall <= 1'b1;
            end else begin
                out_stall <= 1'b0;
            end
        end
    end

    task automatic wait_drain();
        while (pending_items.size() > 0 || in_valid || expected_nodes.size() > 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
    endtask

    task automatic write_count(input int n);
        g_nodes = (n > MAX_NODES) ? MAX_NODES : n;
        cfg_data <= CFG_W'(n);
        cfg_valid <= 1'b1;
        @(posedge i_clk);
        while (!cfg_ready) @(posedge i_clk);
        cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    function automatic t_in_item make_item(input logic k, input int f, input int t);
        t_in_item it;
        it.kind = k;
        it.from_node = ID_W'(f);
        it.to_node = ID_W'(t);
        return it;
    endfunction

    // well-formed graph: mostly in-range edges, a few out of range, then go
    task automatic queue_graph(input int n, input int edges);
        for (int i = 0; i < edges; i++) begin
            if ($urandom_range(0, 15) == 0)
                queue_item(make_item(KIND_EDGE, $urandom_range(0, 127),
                                     $urandom_range(0, 127)));
            else
                queue_item(make_item(KIND_EDGE, $urandom_range(1, n),
                                     $urandom_range(1, n)));
        end
        queue_item(make_item(KIND_GO, $urandom_range(0, 127), $urandom_range(0, 127)));
    endtask

    initial begin
        int n;
        g_nodes = 1;
        clear_model();
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed: single node with a self loop, then a go with no edges
        queue_item(make_item(KIND_EDGE, 1, 1));
        queue_item(make_item(KIND_EDGE, 0, 1));
        queue_item(make_item(KIND_GO, 0, 0));
        queue_item(make_item(KIND_GO, 127, 127));
        wait_drain();

        // directed: zero node count emits nothing
        write_count(0);
        queue_item(make_item(KIND_EDGE, 1, 1));
        queue_item(make_item(KIND_GO, 0, 0));
        wait_drain();

        // directed: full size, cycle 1->2->3->1, chain and out-of-range edges
        write_count(64);
        queue_item(make_item(KIND_EDGE, 1, 2));
        queue_item(make_item(KIND_EDGE, 2, 3));
        queue_item(make_item(KIND_EDGE, 3, 1));
        queue_item(make_item(KIND_EDGE, 3, 64));
        queue_item(make_item(KIND_EDGE, 64, 63));
        queue_item(make_item(KIND_EDGE, 65, 1));
        queue_item(make_item(KIND_EDGE, 1, 127));
        queue_item(make_item(KIND_GO, 0, 0));
        wait_drain();

        // directed: count lowered after edges stored, then saturation above 64
        write_count(8);
        queue_item(make_item(KIND_EDGE, 8, 1));
        queue_item(make_item(KIND_EDGE, 1, 8));
        queue_item(make_item(KIND_EDGE, 7, 8));
        wait_drain();
        write_count(5);
        queue_item(make_item(KIND_GO, 0, 0));
        wait_drain();
        write_count(127);
        queue_item(make_item(KIND_EDGE, 64, 1));
        queue_item(make_item(KIND_GO, 0, 0));
        wait_drain();

        // edge store overflow, receiver held off while the search emits
        write_count(4);
        for (int i = 0; i < MAX_EDGES + 2; i++)
            queue_item(make_item(KIND_EDGE, $urandom_range(1, 4), $urandom_range(1, 4)));
        queue_item(make_item(KIND_GO, 0, 0));
        queue_graph(4, 3);
        while (pending_items.size() > 4) @(posedge i_clk);
        hold_armed = 1'b1;
        wait_drain();

        // random graphs over several node counts
        for (int ph = 0; ph < 4; ph++) begin
            n = (ph == 0) ? 1 : (ph == 3) ? 64 : $urandom_range(2, 20);
            if (ph == 3) quiet_tail = 1'b1;
            write_count(n);
            queue_graph(n, (n == 64) ? $urandom_range(12, 20) : $urandom_range(0, 8));
            wait_drain();
        end

        $display("covered %0d edge items and %0d searches, %0d result items checked",
                 edge_count, go_count, results_seen);
        $display("including a full edge store and a long receiver hold-off");
        if (mismatches == 0 && expected_nodes.size() == 0)
            $display("strongly_connected_components regression: pass");
        else
            $display("strongly_connected_components regression: fail");
        $finish;
    end

    // run limit
    initial begin
        #5000000;
        $display("strongly_connected_components regression: fail");
        $finish;
    end
endmodule

@@ strongly_connected_components.f @@
rtl/core/scc_pkg.sv
rtl/core/scc_ram.sv
rtl/core/scc_graph.sv
rtl/core/scc_walk.sv
rtl/core/strongly_connected_components.sv
tb/tb_strongly_connected_components.sv
